FILE: design/rbsc_pkg.sv
package rbsc_pkg;

  localparam int TAG_W      = 5;
  localparam int OP_W       = 8;
  localparam int WORD_W     = 32;
  localparam int REQ_W      = 3;
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 128;

  typedef enum logic [REQ_W-1:0] {
    REQ_NONE     = 3'd0,
    REQ_ALLOC    = 3'd1,
    REQ_SET_ADDR = 3'd2,
    REQ_CHECK    = 3'd3,
    REQ_READ     = 3'd4
  } req_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [TAG_W-1:0]  entry_tag;
    logic [OP_W-1:0]   op_code;
    logic              op_is_store;
    logic [WORD_W-1:0] target;
    logic [WORD_W-1:0] alloc_value;
    logic [TAG_W-1:0]  wait_tag;
    logic              commit_req;
    logic              bus_valid;
    logic [TAG_W-1:0]  bus_tag;
    logic [WORD_W-1:0] bus_value;
  } in_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]  new_tag;
    logic              commit_valid;
    logic [OP_W-1:0]   commit_op;
    logic              commit_store;
    logic [WORD_W-1:0] commit_dest;
    logic [WORD_W-1:0] commit_value;
    logic              store_conflict;
    logic              entry_ready;
    logic [WORD_W-1:0] entry_value;
    logic              buffer_full;
    logic              head_ready;
  } out_item_t;

endpackage

FILE: design/rbsc_core.sv
module rbsc_core #(
  parameter int ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  rbsc_pkg::in_item_t  item,
  output rbsc_pkg::out_item_t result
);
  import rbsc_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = IW + 1;
  localparam int XW = (CW > TAG_W) ? CW : TAG_W;

  logic              busy_r  [ENTRIES];
  logic              ready_r [ENTRIES];
  logic [OP_W-1:0]   op_r    [ENTRIES];
  logic              store_r [ENTRIES];
  logic [WORD_W-1:0] dest_r  [ENTRIES];
  logic [WORD_W-1:0] data_r  [ENTRIES];
  logic [TAG_W-1:0]  wait_r  [ENTRIES];
  logic [IW-1:0]     head_r;
  logic [IW-1:0]     tail_r;
  logic              empty_r;

  logic              busy_nxt  [ENTRIES];
  logic              ready_nxt [ENTRIES];
  logic [OP_W-1:0]   op_nxt    [ENTRIES];
  logic              store_nxt [ENTRIES];
  logic [WORD_W-1:0] dest_nxt  [ENTRIES];
  logic [WORD_W-1:0] data_nxt  [ENTRIES];
  logic [TAG_W-1:0]  wait_nxt  [ENTRIES];
  logic [IW-1:0]     head_nxt;
  logic [IW-1:0]     tail_nxt;
  logic              empty_nxt;

  logic               full;
  logic               tag_ok;
  logic [IW-1:0]      slot_sel;
  logic [ENTRIES-1:0] hit_vec;
  logic               alloc_done;
  logic               commit_done;
  logic               in_rng;

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] s);
    logic [CW-1:0] inc;
    inc = CW'(s) + CW'(1);
    return (inc >= CW'(ENTRIES)) ? '0 : IW'(inc);
  endfunction

  always_comb begin
    busy_nxt    = busy_r;
    ready_nxt   = ready_r;
    op_nxt      = op_r;
    store_nxt   = store_r;
    dest_nxt    = dest_r;
    data_nxt    = data_r;
    wait_nxt    = wait_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    alloc_done  = 1'b0;
    commit_done = 1'b0;
    result      = '0;
    in_rng      = 1'b0;

    full     = !empty_r && (head_r == tail_r);
    tag_ok   = (item.entry_tag != '0) && (XW'(item.entry_tag) <= XW'(ENTRIES));
    slot_sel = IW'(XW'(item.entry_tag) - XW'(1));

    for (int i = 0; i < ENTRIES; i++) begin
      if (item.bus_valid && busy_r[i] && !ready_r[i]) begin
        if (XW'(item.bus_tag) == XW'(i + 1)) begin
          data_nxt[i]  = item.bus_value;
          ready_nxt[i] = 1'b1;
        end
        if (store_r[i] && (wait_r[i] != '0) && (wait_r[i] == item.bus_tag)) begin
          data_nxt[i] = item.bus_value;
          wait_nxt[i] = '0;
          if (dest_r[i] != '0) begin
            ready_nxt[i] = 1'b1;
          end
        end
      end
      if (head_r <= slot_sel) begin
        in_rng = (head_r <= IW'(i)) && (IW'(i) <= slot_sel);
      end else begin
        in_rng = (IW'(i) >= head_r) || (IW'(i) <= slot_sel);
      end
      hit_vec[i] = in_rng && busy_r[i] && store_r[i] && (dest_r[i] == item.target);
    end

    case (item.req_type)
      REQ_ALLOC: begin
        if (!full) begin
          op_nxt[tail_r]    = item.op_code;
          store_nxt[tail_r] = item.op_is_store;
          dest_nxt[tail_r]  = item.target;
          data_nxt[tail_r]  = item.alloc_value;
          wait_nxt[tail_r]  = item.wait_tag;
          ready_nxt[tail_r] = 1'b0;
          busy_nxt[tail_r]  = 1'b1;
          tail_nxt          = next_slot(tail_r);
          alloc_done        = 1'b1;
          result.new_tag    = TAG_W'(XW'(tail_r) + XW'(1));
        end
      end
      REQ_SET_ADDR: begin
        if (tag_ok && busy_r[slot_sel]) begin
          dest_nxt[slot_sel] = item.target;
          if (wait_nxt[slot_sel] == '0) begin
            ready_nxt[slot_sel] = 1'b1;
          end
        end
      end
      REQ_CHECK: begin
        if (tag_ok) begin
          result.store_conflict = |hit_vec;
        end
      end
      REQ_READ: begin
        if (tag_ok) begin
          result.entry_ready = ready_r[slot_sel];
          result.entry_value = data_r[slot_sel];
        end
      end
      default: begin
      end
    endcase

    if (item.commit_req && !empty_r) begin
      result.commit_valid = 1'b1;
      result.commit_op    = op_r[head_r];
      result.commit_store = store_r[head_r];
      result.commit_dest  = dest_r[head_r];
      result.commit_value = data_r[head_r];
      busy_nxt[head_r]    = 1'b0;
      head_nxt            = next_slot(head_r);
      commit_done         = 1'b1;
    end

    if (alloc_done && !commit_done) begin
      empty_nxt = 1'b0;
    end else if (commit_done && !alloc_done) begin
      empty_nxt = (head_nxt == tail_nxt);
    end else begin
      empty_nxt = empty_r;
    end

    result.buffer_full = !empty_nxt && (head_nxt == tail_nxt);
    result.head_ready  = !empty_nxt && ready_nxt[head_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= '{default: 1'b0};
      ready_r <= '{default: 1'b0};
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else if (fire) begin
      busy_r  <= busy_nxt;
      ready_r <= ready_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      op_r    <= op_nxt;
      store_r <= store_nxt;
      dest_r  <= dest_nxt;
      data_r  <= data_nxt;
      wait_r  <= wait_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_empty_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (head_r == tail_r) && !busy_r[head_r])
    else $error("Empty buffer holds a busy head entry.");

  a_commit_frees_head: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.commit_req && !empty_r) |=> !busy_r[$past(head_r)])
    else $error("Committed entry is still busy.");

  a_alloc_fills_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (item.req_type == REQ_ALLOC) && !full) |=>
      busy_r[$past(tail_r)] && !ready_r[$past(tail_r)])
    else $error("Allocated entry is not busy and waiting.");

  a_full_refuses: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && full) |-> (result.new_tag == '0))
    else $error("Allocation granted on a full buffer.");
`endif

endmodule

FILE: design/reorder_buffer_with_store_check.sv
// Channel  Ports                       Payload
// -------  --------------------------  --------------------------------------------
// input    in_tvalid/in_tready         in_tuser: req_type; in_tdata: request,
//                                      commit and broadcast fields
// result   out_tvalid/out_tready       out_tdata: allocate, commit, check, read
//                                      and status fields
//
// Each transfer is one processor cycle of the buffer and yields exactly one result.
// An item passes an input register and then a result register; its result is offered
// once the item has moved into it, which happens only while that register is free or
// its result transfers. One item is accepted per clock when the result side takes
// results. The input side stays ready while the input register is free, even when a
// result waits. Reset (synchronous, active low) empties the buffer at once.
module reorder_buffer_with_store_check #(
  parameter int ENTRIES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // in_tdata: entry_tag[4:0], op_code[12:5], op_is_store[13], target[45:14],
  // alloc_value[77:46], wait_tag[82:78], commit_req[83], bus_valid[84],
  // bus_tag[89:85], bus_value[121:90], zeros above.
  input  logic [rbsc_pkg::IN_DATA_W-1:0]       in_tdata,
  // in_tuser: req_type[2:0].
  input  logic [rbsc_pkg::REQ_W-1:0]           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // out_tdata: new_tag[4:0], commit_valid[5], commit_op[13:6], commit_store[14],
  // commit_dest[46:15], commit_value[78:47], store_conflict[79], entry_ready[80],
  // entry_value[112:81], buffer_full[113], head_ready[114], zeros above.
  output logic [rbsc_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import rbsc_pkg::*;

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  in_item_t  in_item;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t core_result;
  logic      out_free;
  logic      advance;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_comb begin
    in_item.req_type    = in_tuser;
    in_item.entry_tag   = in_tdata[4:0];
    in_item.op_code     = in_tdata[12:5];
    in_item.op_is_store = in_tdata[13];
    in_item.target      = in_tdata[45:14];
    in_item.alloc_value = in_tdata[77:46];
    in_item.wait_tag    = in_tdata[82:78];
    in_item.commit_req  = in_tdata[83];
    in_item.bus_valid   = in_tdata[84];
    in_item.bus_tag     = in_tdata[89:85];
    in_item.bus_value   = in_tdata[121:90];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= core_result;
    end
  end

  rbsc_core #(
    .ENTRIES (ENTRIES)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (s1_item_r),
    .result (core_result)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {13'b0,
                       out_item_r.head_ready,
                       out_item_r.buffer_full,
                       out_item_r.entry_value,
                       out_item_r.entry_ready,
                       out_item_r.store_conflict,
                       out_item_r.commit_value,
                       out_item_r.commit_dest,
                       out_item_r.commit_store,
                       out_item_r.commit_op,
                       out_item_r.commit_valid,
                       out_item_r.new_tag};

endmodule
